@@ rtl/utf8_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder assertion macros
// Shared concurrent assertion forms, clocked on clk; all but the ALWAYS form are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define U8SD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8sd assertion failed");

// next-cycle implication, disabled in reset
`define U8SD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8sd assertion failed");

// checked in reset as well
`define U8SD_ASSERT_ALWAYS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("u8sd assertion failed");

`endif

@@ rtl/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MIN  = 8'h80;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_error;
		logic            last_of_run;
	} out_item_t;

endpackage

@@ rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Lenient UTF-8 decoder: one byte per request, emits completed code points.
// Path: a taken byte is registered in the input stage, then decoded into a
// four-entry result queue whose head drives the output. Throughput: one byte
// per cycle while the queue has room for two; a byte may give two results.
// Reset: asynchronous; clears decode state, queue and input stage, and loads
// the replacement code point with U+FFFD.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  u8sd_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output u8sd_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [u8sd_pkg::CP_W-1:0]   cfg_wdata
);
	import u8sd_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [CP_W-1:0]  repl_q;
	logic             valid_s1;
	in_item_t         item_s1;
	logic [1:0]       pend_q;
	logic [CP_W-1:0]  part_q;

	out_item_t        fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic             pop;
	logic [CNT_W-1:0] cnt_left;
	logic             adv;

	logic [7:0]       c;
	logic             emit_pre;
	logic             emit_main;
	logic             emit_eos;
	logic [CP_W-1:0]  main_cp;
	logic             main_err;
	logic [1:0]       pend_n;
	logic [CP_W-1:0]  part_n;
	logic [1:0]       n_res;
	out_item_t        slot0;
	out_item_t        slot1;

	assign pop       = out_valid & out_ready;
	assign cnt_left  = cnt_q - CNT_W'(pop);
	assign adv       = valid_s1 & (cnt_left <= CNT_W'(FIFO_DEPTH - 2));
	assign in_ready  = ~valid_s1 | adv;
	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[rd_q];

	// decode of the staged byte
	always_comb begin
		c         = item_s1.in_byte;
		emit_pre  = 1'b0;
		emit_main = 1'b0;
		main_cp   = repl_q;
		main_err  = 1'b1;
		pend_n    = pend_q;
		part_n    = part_q;
		if (c inside {[8'h00:ASCII_MAX]}) begin
			emit_pre  = (pend_q != 2'd0);
			emit_main = 1'b1;
			main_cp   = CP_W'(c);
			main_err  = 1'b0;
			pend_n    = 2'd0;
		end else if (c inside {[CONT_MIN:CONT_MAX]}) begin
			if (pend_q != 2'd0) begin
				part_n    = {part_q[CP_W-7:0], c[5:0]};
				pend_n    = pend_q - 2'd1;
				emit_main = (pend_q == 2'd1);
				main_cp   = {part_q[CP_W-7:0], c[5:0]};
				main_err  = 1'b0;
			end else begin
				emit_main = 1'b1;
			end
		end else if (c inside {[LEAD2_MIN:LEAD2_MAX]}) begin
			pend_n = 2'd1;
			part_n = CP_W'(c[4:0]);
		end else if (c inside {[LEAD3_MIN:LEAD3_MAX]}) begin
			pend_n = 2'd2;
			part_n = CP_W'(c[3:0]);
		end else if (c inside {[LEAD4_MIN:LEAD4_MAX]}) begin
			pend_n = 2'd3;
			part_n = CP_W'(c[2:0]);
		end else begin
			emit_main = 1'b1;
			pend_n    = 2'd0;
		end
		emit_eos = item_s1.end_of_string & (pend_n != 2'd0);
		if (item_s1.end_of_string) begin
			pend_n = 2'd0;
			part_n = '0;
		end
		n_res = 2'(emit_pre) + 2'(emit_main) + 2'(emit_eos);

		// at most two of the three fire; a leading replacement is never last
		slot0.code_point  = emit_pre ? repl_q : (emit_main ? main_cp : repl_q);
		slot0.is_error    = emit_pre ? 1'b1 : (emit_main ? main_err : 1'b1);
		slot0.last_of_run = (n_res == 2'd1);
		slot1.code_point  = main_cp;
		slot1.is_error    = main_err;
		slot1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q   <= REPL_RESET;
			valid_s1 <= 1'b0;
			pend_q   <= 2'd0;
			part_q   <= '0;
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				repl_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				pend_q <= pend_n;
				part_q <= part_n;
				wr_q   <= wr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_left + (adv ? CNT_W'(n_res) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv && (n_res != 2'd0)) begin
			fifo_q[wr_q] <= slot0;
		end
		if (adv && (n_res == 2'd2)) begin
			fifo_q[wr_q + PTR_W'(1)] <= slot1;
		end
	end

endmodule

@@ rtl/u8sd_checker.sv @@
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks for the UTF-8 stream decoder, bound into the decoder module.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module u8sd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input u8sd_pkg::out_item_t  out_data
);
	import u8sd_pkg::*;

	`U8SD_ASSERT_ALWAYS(a_rst_quiet, !arst_n, !out_valid)
	`U8SD_ASSERT_NOW(a_pair_head_err, out_valid && !out_data.last_of_run, out_data.is_error)
	`U8SD_ASSERT_NEXT(a_pair_tail, out_valid && out_ready && !out_data.last_of_run, out_valid)
	`U8SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`U8SD_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (.*);

@@ tb/tb_utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Self-checking bench for the UTF-8 stream decoder. Byte requests come from a
// queue that the stimulus process fills: a directed run over the byte classes
// and malformed cases, then mostly well-formed random strings with noise and
// truncated sequences, under several replacement code points. A local decoder
// model predicts each result, and the monitor checks results in order.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
	import u8sd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;
	localparam int LONG_HOLD   = 80;
	localparam int DRAIN_WAIT  = 6;
	localparam int MAX_SHOWN   = 10;

	typedef struct {
		in_item_t    req;
		int unsigned gap;
	} byte_req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [CP_W-1:0] cfg_wdata = '0;

	// decoder model state
	logic [1:0]      pend_cont  = '0;
	logic [CP_W-1:0] partial_cp = '0;
	logic [CP_W-1:0] repl_cp    = REPL_RESET;

	byte_req_t   byte_req_q[$];
	out_item_t   cp_expect_q[$];
	out_item_t   want;
	int unsigned bytes_queued  = 0;
	int unsigned bytes_taken   = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatches    = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned max_gap       = 10;
	int unsigned rx_max        = 10;
	int unsigned hold_reqs     = 0;
	int unsigned holds_served  = 0;
	logic        in_taken      = 1'b0;
	logic        out_taken     = 1'b0;

	// driver state
	byte_req_t   cur_req;
	logic        have_req      = 1'b0;
	int unsigned tx_wait       = 0;

	// receiver state
	int unsigned rx_wait       = 0;
	int unsigned hold_left     = 0;

	utf8_stream_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic out_item_t mk_cp(input logic [CP_W-1:0] cp, input logic err);
		out_item_t r;
		r.code_point  = cp;
		r.is_error    = err;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic void decode_byte(input in_item_t req);
		out_item_t   r[2];
		int unsigned n;
		logic [7:0]  b;
		n = 0;
		b = req.in_byte;
		if (b <= ASCII_MAX) begin
			if (pend_cont != 0) begin
				r[n] = mk_cp(repl_cp, 1'b1);
				n++;
				pend_cont = '0;
			end
			r[n] = mk_cp({13'd0, b}, 1'b0);
			n++;
		end else if (b <= CONT_MAX) begin
			if (pend_cont != 0) begin
				partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
				pend_cont  = pend_cont - 2'd1;
				if (pend_cont == 0) begin
					r[n] = mk_cp(partial_cp, 1'b0);
					n++;
				end
			end else begin
				r[n] = mk_cp(repl_cp, 1'b1);
				n++;
			end
		end else if (b <= LEAD2_MAX) begin
			pend_cont  = 2'd1;
			partial_cp = {16'd0, b[4:0]};
		end else if (b <= LEAD3_MAX) begin
			pend_cont  = 2'd2;
			partial_cp = {17'd0, b[3:0]};
		end else if (b <= LEAD4_MAX) begin
			pend_cont  = 2'd3;
			partial_cp = {18'd0, b[2:0]};
		end else begin
			r[n] = mk_cp(repl_cp, 1'b1);
			n++;
			pend_cont = '0;
		end
		if (req.end_of_string) begin
			if (pend_cont != 0) begin
				r[n] = mk_cp(repl_cp, 1'b1);
				n++;
			end
			pend_cont  = '0;
			partial_cp = '0;
		end
		if (n > 0)
			r[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			cp_expect_q.insert(cp_expect_q.size(), r[i]);
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic eos);
		byte_req_t br;
		br.req.in_byte       = b;
		br.req.end_of_string = eos;
		br.gap               = $urandom_range(0, max_gap);
		byte_req_q.insert(byte_req_q.size(), br);
		bytes_queued++;
	endtask

	task automatic queue_seq(input logic [7:0] s[$], input logic eos);
		for (int i = 0; i < s.size(); i++)
			queue_byte(s[i], eos && (i == s.size() - 1));
	endtask

	// mostly well-formed strings; some noise bytes and cut-short sequences
	task automatic queue_string();
		logic [7:0]  s[$];
		logic [7:0]  lead;
		int unsigned n_chars;
		int unsigned kind;
		int unsigned n_cont;
		n_chars = $urandom_range(1, 8);
		for (int i = 0; i < n_chars; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				s.insert(s.size(), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						lead   = 8'($urandom_range(0, ASCII_MAX));
						n_cont = 0;
					end
					1: begin
						lead   = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
						n_cont = 1;
					end
					2: begin
						lead   = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
						n_cont = 2;
					end
					default: begin
						lead   = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
						n_cont = 3;
					end
				endcase
				if (kind < 20 && n_cont > 0)
					n_cont = $urandom_range(0, n_cont - 1);
				s.insert(s.size(), lead);
				for (int k = 0; k < n_cont; k++)
					s.insert(s.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
			end
		end
		queue_seq(s, $urandom_range(0, 9) != 0);
	endtask

	task automatic drain();
		while (bytes_taken != bytes_queued || cp_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_repl(input logic [CP_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		repl_cp   = v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_taken)) begin
			if (!have_req && byte_req_q.size() != 0) begin
				cur_req  = byte_req_q.pop_front();
				tx_wait  = cur_req.gap;
				have_req = 1'b1;
			end
			if (have_req && tx_wait == 0) begin
				in_valid <= 1'b1;
				in_data  <= cur_req.req;
				have_req = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (have_req)
					tx_wait--;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_reqs != holds_served) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (out_taken)
			rx_wait = $urandom_range(0, rx_max);
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		in_taken  <= arst_n && in_valid && in_ready;
		out_taken <= arst_n && out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (cp_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("result %0d unexpected: cp=%h err=%b last=%b",
							results_seen, out_data.code_point, out_data.is_error,
							out_data.last_of_run);
				end else begin
					want = cp_expect_q.pop_front();
					if (out_data.code_point !== want.code_point
						|| out_data.is_error !== want.is_error
						|| out_data.last_of_run !== want.last_of_run) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("result %0d: exp cp=%h err=%b last=%b, got cp=%h err=%b last=%b",
								results_seen, want.code_point, want.is_error,
								want.last_of_run, out_data.code_point, out_data.is_error,
								out_data.last_of_run);
					end
				end
			end
			if (in_valid && in_ready) begin
				decode_byte(in_data);
				bytes_taken++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [CP_W-1:0] v;
		int unsigned     start;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// byte classes and malformed input under the reset replacement
		queue_seq('{8'h00}, 1'b0);
		queue_seq('{8'h7F}, 1'b0);
		queue_seq('{8'hC2, 8'hA9}, 1'b0);
		queue_seq('{8'hE2, 8'h82, 8'hAC}, 1'b0);
		queue_seq('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
		queue_seq('{8'h80}, 1'b0);
		queue_seq('{8'hE2, 8'h41}, 1'b0);
		queue_seq('{8'hC3, 8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);
		queue_seq('{8'hE2, 8'hFF}, 1'b0);
		queue_seq('{8'hF8}, 1'b0);
		queue_seq('{8'hD0}, 1'b1);
		queue_seq('{8'hE0, 8'hBF}, 1'b1);
		queue_seq('{8'h41}, 1'b1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       v = '0;
				1:       v = 21'h10FFFF;
				default: v = CP_W'($urandom_range(0, 21'h10FFFF));
			endcase
			write_repl(v);
			max_gap = (ph % 3 == 1 || ph == 2) ? 0 : 10;
			rx_max  = (ph % 3 == 2) ? 0 : 10;
			// receiver backs off while bytes stream in, so the block fills up
			if (ph == 2)
				hold_reqs++;
			start = bytes_queued;
			while (bytes_queued - start < 200)
				queue_string();
			drain();
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0 && cp_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/u8sd_pkg.sv
rtl/utf8_stream_decoder.sv
rtl/u8sd_checker.sv
tb/tb_utf8_stream_decoder.sv
